// File: rtl/gdme_pkg.sv
package gdme_pkg;

    localparam int LIMIT_WIDTH     = 32;
    localparam int FREQ_PORT_WIDTH = 16;
    localparam int INDEX_WIDTH     = 16;
    localparam int MAG_WIDTH       = LIMIT_WIDTH + 1;

    typedef logic signed [LIMIT_WIDTH-1:0] t_limit;
    typedef logic [FREQ_PORT_WIDTH-1:0]    t_freq;
    typedef logic [INDEX_WIDTH-1:0]        t_index;
    typedef logic signed [MAG_WIDTH-1:0]   t_width;

endpackage

// File: rtl/grouped_data_mode_estimator.sv
// Channel  Valid     Ready     Payload
// class    i_valid   o_ready   i_lower_limit, i_upper_limit, i_frequency, i_last_class
// result   o_valid   i_ready   o_mode_value, o_modal_index, o_zero_denominator
//
// A class word is accepted while the block is idle. A last-class word then starts
// the mode calculation: a setup step, a bit-serial multiply, a bit-serial restoring
// divide and the final add, during which o_ready is low. A zero denominator skips multiply
// and divide. The result register frees the datapath once loaded; the final add
// waits while the result register is full and not being taken. Reset is synchronous.
module grouped_data_mode_estimator #(
    parameter int FREQ_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  gdme_pkg::t_limit i_lower_limit,
    input  gdme_pkg::t_limit i_upper_limit,
    input  gdme_pkg::t_freq  i_frequency,
    input  logic             i_last_class,
    output logic             o_valid,
    input  logic             i_ready,
    output gdme_pkg::t_limit o_mode_value,
    output gdme_pkg::t_index o_modal_index,
    output logic             o_zero_denominator
);
    import gdme_pkg::*;

    localparam int FW = (FREQ_WIDTH < FREQ_PORT_WIDTH) ? FREQ_WIDTH : FREQ_PORT_WIDTH;
    localparam int PW = FW + MAG_WIDTH;
    localparam int CW = $clog2(PW + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    localparam t_index IDX_MAX = '1;

    // control
    logic [2:0]    r_state, n_state;
    t_index        r_count, n_count;
    logic          r_out_valid, n_out_valid;
    // running maximum
    logic [FW-1:0] r_prev, n_prev;
    logic [FW-1:0] r_best, n_best;
    logic [FW-1:0] r_before, n_before;
    logic [FW-1:0] r_after, n_after;
    t_limit        r_lower, n_lower;
    t_width        r_width, n_width;
    t_index        r_index, n_index;
    logic          r_newest, n_newest;
    // serial datapath
    logic [FW-1:0] r_num, n_num;
    logic [FW:0]   r_den, n_den;
    logic          r_neg, n_neg;
    logic          r_zero, n_zero;
    logic [PW-1:0] r_prod, n_prod;
    logic [FW:0]   r_rem, n_rem;
    logic [CW-1:0] r_cnt, n_cnt;
    // result
    t_limit        r_mode, n_mode;
    t_index        r_idx_o, n_idx_o;
    logic          r_zero_o, n_zero_o;

    logic            accept;
    logic            first;
    logic [FW-1:0]   freq;
    logic [FW-1:0]   num;
    logic [FW:0]     den;
    logic [MAG_WIDTH-1:0] mag;
    logic [FW:0]     mul_sum;
    logic [FW+1:0]   trial;
    logic [FW+1:0]   trial_sub;
    logic signed [MAG_WIDTH:0] sum;
    logic            out_free;

    assign o_ready            = (r_state == S_IDLE);
    assign accept             = i_valid && o_ready;
    assign first              = (r_count == '0);
    assign freq               = i_frequency[FW-1:0];
    assign out_free           = !r_out_valid || i_ready;
    assign o_valid            = r_out_valid;
    assign o_mode_value       = r_mode;
    assign o_modal_index      = r_idx_o;
    assign o_zero_denominator = r_zero_o;

    assign num       = r_best - r_before;
    assign den       = {1'b0, num} + {1'b0, r_best - r_after};
    assign mag       = r_width[MAG_WIDTH-1] ? MAG_WIDTH'(-r_width) : MAG_WIDTH'(r_width);
    assign mul_sum   = {1'b0, r_prod[PW-1:MAG_WIDTH]} + (r_prod[0] ? {1'b0, r_num} : '0);
    assign trial     = {r_rem, r_prod[PW-1]};
    assign trial_sub = trial - {1'b0, r_den};
    assign sum       = r_neg
                     ? ((MAG_WIDTH+1)'(r_lower) - $signed({1'b0, r_prod[MAG_WIDTH-1:0]}))
                     : ((MAG_WIDTH+1)'(r_lower) + $signed({1'b0, r_prod[MAG_WIDTH-1:0]}));

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        n_prev      = r_prev;
        n_best      = r_best;
        n_before    = r_before;
        n_after     = r_after;
        n_lower     = r_lower;
        n_width     = r_width;
        n_index     = r_index;
        n_newest    = r_newest;
        n_num       = r_num;
        n_den       = r_den;
        n_neg       = r_neg;
        n_zero      = r_zero;
        n_prod      = r_prod;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_mode      = r_mode;
        n_idx_o     = r_idx_o;
        n_zero_o    = r_zero_o;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (first || freq > r_best) begin
                        n_best   = freq;
                        n_before = first ? '0 : r_prev;
                        n_after  = '0;
                        n_lower  = i_lower_limit;
                        n_width  = MAG_WIDTH'(i_upper_limit) - MAG_WIDTH'(i_lower_limit);
                        n_index  = r_count;
                        n_newest = 1'b1;
                    end else if (r_newest) begin
                        n_after  = freq;
                        n_newest = 1'b0;
                    end
                    n_prev = freq;
                    if (r_count != IDX_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                    if (i_last_class) begin
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                n_count = '0;
                n_num   = num;
                n_den   = den;
                n_neg   = r_width[MAG_WIDTH-1];
                n_rem   = '0;
                if (den == '0) begin
                    n_zero  = 1'b1;
                    n_prod  = '0;
                    n_state = S_FIN;
                end else begin
                    n_zero  = 1'b0;
                    n_prod  = {{FW{1'b0}}, mag};
                    n_cnt   = CW'(MAG_WIDTH - 1);
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod = {mul_sum, r_prod[MAG_WIDTH-1:1]};
                if (r_cnt == '0) begin
                    n_cnt   = CW'(PW - 1);
                    n_state = S_DIV;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DIV: begin
                if (!trial_sub[FW+1]) begin
                    n_rem  = trial_sub[FW:0];
                    n_prod = {r_prod[PW-2:0], 1'b1};
                end else begin
                    n_rem  = trial[FW:0];
                    n_prod = {r_prod[PW-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    if (sum > (MAG_WIDTH+1)'($signed(32'sh7FFF_FFFF))) begin
                        n_mode = 32'sh7FFF_FFFF;
                    end else if (sum < (MAG_WIDTH+1)'($signed(32'sh8000_0000))) begin
                        n_mode = 32'sh8000_0000;
                    end else begin
                        n_mode = sum[LIMIT_WIDTH-1:0];
                    end
                    n_idx_o     = r_index;
                    n_zero_o    = r_zero;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev   <= n_prev;
        r_best   <= n_best;
        r_before <= n_before;
        r_after  <= n_after;
        r_lower  <= n_lower;
        r_width  <= n_width;
        r_index  <= n_index;
        r_newest <= n_newest;
        r_num    <= n_num;
        r_den    <= n_den;
        r_neg    <= n_neg;
        r_zero   <= n_zero;
        r_prod   <= n_prod;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_mode   <= n_mode;
        r_idx_o  <= n_idx_o;
        r_zero_o <= n_zero_o;
    end

endmodule
